[sv/rgpg_pkg.sv]
package rgpg_pkg;

    // Table geometry: both stores have one entry per 8-bit index.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int RADIUS_W    = 8;
    localparam int COLOR_W     = 16;
    localparam int DATA_W      = 16;

    // Port field widths.
    localparam int OPCODE_W    = 2;
    localparam int PIX_COORD_W = 10;
    localparam int NOISE_W     = 8;

    // Configuration port.
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int CENTER_W    = 10;
    localparam int BREATHE_W   = 7;
    localparam int GAIN_W      = 4;

    // Reset values of the configuration registers.
    localparam logic [CENTER_W-1:0]         CENTER_X_RST = CENTER_W'(240);
    localparam logic [CENTER_W-1:0]         CENTER_Y_RST = CENTER_W'(260);
    localparam logic signed [BREATHE_W-1:0] BREATHE_RST  = '0;
    localparam logic [GAIN_W-1:0]           GAIN_RST     = GAIN_W'(2);

    // Pixel arithmetic.
    localparam int NOISE_CENTER  = 128;
    localparam int FLICKER_SHIFT = 7;
    localparam int DITHER_W      = 4;
    localparam int FLICKER_W     = 6;
    localparam int OFS_W         = 8;

    // Defaults of the top-level parameters.
    localparam int RADIUS_SHIFT_DEF = 9;
    localparam int COORD_WIDTH_DEF  = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PIXEL      = 2'd0,
        OP_RADIUS_WR  = 2'd1,
        OP_PALETTE_WR = 2'd2
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_BREATHE  = 2'd2,
        CFG_GAIN     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CENTER_W-1:0]         center_x;
        logic [CENTER_W-1:0]         center_y;
        logic signed [BREATHE_W-1:0] breathe;
        logic [GAIN_W-1:0]           gain;
    } t_cfg;

    // Control part of an item as it moves down the pipeline.
    typedef struct packed {
        t_opcode           op;
        logic [IDX_W-1:0]  tidx;
        logic [DATA_W-1:0] tdata;
    } t_item_ctl;

    // 8x8 ordered dither matrix, row-major, row taken from y and column from x.
    localparam logic [5:0] BAYER [64] = '{
         0, 32,  8, 40,  2, 34, 10, 42,
        48, 16, 56, 24, 50, 18, 58, 26,
        12, 44,  4, 36, 14, 46,  6, 38,
        60, 28, 52, 20, 62, 30, 54, 22,
         3, 35, 11, 43,  1, 33,  9, 41,
        51, 19, 59, 27, 49, 17, 57, 25,
        15, 47,  7, 39, 13, 45,  5, 37,
        63, 31, 55, 23, 61, 29, 53, 21
    };

    // Dither term (b - 31) / 5 truncated toward zero, as ranges of the matrix value.
    function automatic logic signed [DITHER_W-1:0] bayer_dither(
        input logic [2:0] row,
        input logic [2:0] col
    );
        logic [5:0]                 b;
        logic signed [DITHER_W-1:0] d;
        b = BAYER[{row, col}];
        case (b) inside
            [6'd0:6'd1]:   d = -4'sd6;
            [6'd2:6'd6]:   d = -4'sd5;
            [6'd7:6'd11]:  d = -4'sd4;
            [6'd12:6'd16]: d = -4'sd3;
            [6'd17:6'd21]: d = -4'sd2;
            [6'd22:6'd26]: d = -4'sd1;
            [6'd27:6'd35]: d = 4'sd0;
            [6'd36:6'd40]: d = 4'sd1;
            [6'd41:6'd45]: d = 4'sd2;
            [6'd46:6'd50]: d = 4'sd3;
            [6'd51:6'd55]: d = 4'sd4;
            [6'd56:6'd60]: d = 4'sd5;
            default:       d = 4'sd6;
        endcase
        return d;
    endfunction

endpackage

[sv/rgpg_geom.sv]
module rgpg_geom #(
    parameter int COORD_WIDTH = rgpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_load,
    input  logic [rgpg_pkg::PIX_COORD_W-1:0]        i_pixel_x,
    input  logic [rgpg_pkg::PIX_COORD_W-1:0]        i_pixel_y,
    input  logic [rgpg_pkg::NOISE_W-1:0]            i_noise_sample,
    input  rgpg_pkg::t_cfg                          i_cfg,
    input  rgpg_pkg::t_item_ctl                     i_ctl,
    output logic [2*COORD_WIDTH-1:0]                o_sq_x,
    output logic [2*COORD_WIDTH-1:0]                o_sq_y,
    output logic signed [rgpg_pkg::DITHER_W-1:0]    o_dither,
    output logic signed [rgpg_pkg::FLICKER_W-1:0]   o_flicker,
    output rgpg_pkg::t_item_ctl                     o_ctl
);
    import rgpg_pkg::*;

    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int PROD_W = NOISE_W + GAIN_W + 2;

    logic [COORD_WIDTH-1:0]       x_c;
    logic [COORD_WIDTH-1:0]       y_c;
    logic [COORD_WIDTH-1:0]       cx_c;
    logic [COORD_WIDTH-1:0]       cy_c;
    logic [COORD_WIDTH-1:0]       dx;
    logic [COORD_WIDTH-1:0]       dy;
    logic [SQ_W-1:0]              sq_x;
    logic [SQ_W-1:0]              sq_y;
    logic signed [NOISE_W:0]      noise_c;
    logic signed [GAIN_W:0]       gain_s;
    logic signed [PROD_W-1:0]     prod;

    logic [SQ_W-1:0]              r_sq_x;
    logic [SQ_W-1:0]              r_sq_y;
    logic signed [DITHER_W-1:0]   r_dither;
    logic signed [FLICKER_W-1:0]  r_flicker;
    t_item_ctl                    r_ctl;

    // Coordinates keep their low COORD_WIDTH bits.
    assign x_c  = COORD_WIDTH'(i_pixel_x);
    assign y_c  = COORD_WIDTH'(i_pixel_y);
    assign cx_c = COORD_WIDTH'(i_cfg.center_x);
    assign cy_c = COORD_WIDTH'(i_cfg.center_y);

    // Absolute distances to the center and their squares.
    assign dx   = (x_c >= cx_c) ? (x_c - cx_c) : (cx_c - x_c);
    assign dy   = (y_c >= cy_c) ? (y_c - cy_c) : (cy_c - y_c);
    assign sq_x = SQ_W'(dx) * SQ_W'(dx);
    assign sq_y = SQ_W'(dy) * SQ_W'(dy);

    // Flicker: centered noise times gain, arithmetic shift right.
    assign noise_c = signed'({1'b0, i_noise_sample}) - signed'((NOISE_W + 1)'(NOISE_CENTER));
    assign gain_s  = signed'({1'b0, i_cfg.gain});
    assign prod    = noise_c * gain_s;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq_x    <= sq_x;
            r_sq_y    <= sq_y;
            r_dither  <= bayer_dither(i_pixel_y[2:0], i_pixel_x[2:0]);
            r_flicker <= prod[FLICKER_SHIFT +: FLICKER_W];
            r_ctl     <= i_ctl;
        end
    end

    assign o_sq_x    = r_sq_x;
    assign o_sq_y    = r_sq_y;
    assign o_dither  = r_dither;
    assign o_flicker = r_flicker;
    assign o_ctl     = r_ctl;

endmodule

[sv/rgpg_radius.sv]
module rgpg_radius #(
    parameter int COORD_WIDTH  = rgpg_pkg::COORD_WIDTH_DEF,
    parameter int RADIUS_SHIFT = rgpg_pkg::RADIUS_SHIFT_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_load,
    input  logic                                    i_valid,
    input  logic [2*COORD_WIDTH-1:0]                i_sq_x,
    input  logic [2*COORD_WIDTH-1:0]                i_sq_y,
    input  logic signed [rgpg_pkg::DITHER_W-1:0]    i_dither,
    input  logic signed [rgpg_pkg::FLICKER_W-1:0]   i_flicker,
    input  rgpg_pkg::t_cfg                          i_cfg,
    input  rgpg_pkg::t_item_ctl                     i_ctl,
    output logic [rgpg_pkg::RADIUS_W-1:0]           o_radius,
    output logic signed [rgpg_pkg::OFS_W-1:0]       o_offset,
    output rgpg_pkg::t_item_ctl                     o_ctl
);
    import rgpg_pkg::*;

    localparam int R2_W = 2 * COORD_WIDTH + 1;

    logic [R2_W-1:0]          r2;
    logic [R2_W-1:0]          r2_shifted;
    logic [IDX_W-1:0]         ridx;
    logic signed [OFS_W-1:0]  offset;

    logic [RADIUS_W-1:0]      r_radius_mem [TABLE_DEPTH];
    logic [RADIUS_W-1:0]      r_radius;
    logic signed [OFS_W-1:0]  r_offset;
    t_item_ctl                r_ctl;

    // Squared radius, scaled down and saturated to the last table entry.
    assign r2         = R2_W'(i_sq_x) + R2_W'(i_sq_y);
    assign r2_shifted = r2 >> RADIUS_SHIFT;
    assign ridx       = (r2_shifted > R2_W'(TABLE_DEPTH - 1)) ? '1 : r2_shifted[IDX_W-1:0];

    // Dither plus flicker minus breathe, all sign-extended to the offset width.
    assign offset = {{(OFS_W - DITHER_W){i_dither[DITHER_W-1]}}, i_dither}
                  + {{(OFS_W - FLICKER_W){i_flicker[FLICKER_W-1]}}, i_flicker}
                  - {{(OFS_W - BREATHE_W){i_cfg.breathe[BREATHE_W-1]}}, i_cfg.breathe};

    // Radius table: writes and reads happen as items leave this stage, in order.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_valid && i_ctl.op == OP_RADIUS_WR) begin
                r_radius_mem[i_ctl.tidx] <= i_ctl.tdata[RADIUS_W-1:0];
            end
            r_radius <= r_radius_mem[ridx];
            r_offset <= offset;
            r_ctl    <= i_ctl;
        end
    end

    assign o_radius = r_radius;
    assign o_offset = r_offset;
    assign o_ctl    = r_ctl;

endmodule

[sv/rgpg_palette.sv]
module rgpg_palette (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_valid,
    input  logic [rgpg_pkg::RADIUS_W-1:0]       i_radius,
    input  logic signed [rgpg_pkg::OFS_W-1:0]   i_offset,
    input  rgpg_pkg::t_item_ctl                 i_ctl,
    output logic [rgpg_pkg::COLOR_W-1:0]        o_pixel_color
);
    import rgpg_pkg::*;

    localparam int SUM_W = RADIUS_W + 2;

    logic signed [SUM_W-1:0]  sum;
    logic [IDX_W-1:0]         pidx;

    logic [COLOR_W-1:0]       r_palette_mem [TABLE_DEPTH];
    logic [COLOR_W-1:0]       r_color;

    // Palette index: radius entry plus offset, clamped to the table range.
    assign sum = signed'({2'b00, i_radius})
               + {{(SUM_W - OFS_W){i_offset[OFS_W-1]}}, i_offset};

    always_comb begin
        if (sum[SUM_W-1]) begin
            pidx = '0;
        end else if (sum[SUM_W-2:IDX_W] != '0) begin
            pidx = '1;
        end else begin
            pidx = sum[IDX_W-1:0];
        end
    end

    // Palette: write and read as items leave this stage; the read data is the result.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_valid && i_ctl.op == OP_PALETTE_WR) begin
                r_palette_mem[i_ctl.tidx] <= i_ctl.tdata[COLOR_W-1:0];
            end
            r_color <= r_palette_mem[pidx];
        end
    end

    assign o_pixel_color = r_color;

endmodule

[sv/radial_glow_pixel_generator_core.sv]
// Radial glow pixel generator.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per item:
// opcode OP_PIXEL colors the pixel at (i_pixel_x, i_pixel_y) using
// i_noise_sample, OP_RADIUS_WR and OP_PALETTE_WR load entry i_table_index of
// the radius table or the palette from i_table_data. Opcode 3 is dropped.
// Only pixel transactions produce an output transaction (o_out_valid /
// i_out_ready, payload o_pixel_color); results leave in input order.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data; the user
// must write it only while the pipeline is empty; the block does not enforce it.
//
// The datapath is four register stages (input, squares, radius table read,
// palette read). A result is valid once its transaction has reached the palette
// register, and one transaction is taken every cycle while the output
// side keeps up. When the receiver stalls, the stages fill one by one and
// o_in_ready drops only once all four are occupied; empty stages are closed
// up. Reset empties the pipeline and loads the configuration defaults; both
// tables hold unknown contents until they are written.
module radial_glow_pixel_generator_core #(
    parameter int RADIUS_SHIFT = rgpg_pkg::RADIUS_SHIFT_DEF,
    parameter int COORD_WIDTH  = rgpg_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rgpg_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [rgpg_pkg::PIX_COORD_W-1:0]    i_pixel_x,
    input  logic [rgpg_pkg::PIX_COORD_W-1:0]    i_pixel_y,
    input  logic [rgpg_pkg::NOISE_W-1:0]        i_noise_sample,
    input  logic [rgpg_pkg::IDX_W-1:0]          i_table_index,
    input  logic [rgpg_pkg::DATA_W-1:0]         i_table_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rgpg_pkg::COLOR_W-1:0]        o_pixel_color,
    input  logic                                i_cfg_we,
    input  logic [rgpg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rgpg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rgpg_pkg::*;

    t_cfg                           r_cfg;
    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    logic                           r_v4;
    logic [PIX_COORD_W-1:0]         r_pixel_x;
    logic [PIX_COORD_W-1:0]         r_pixel_y;
    logic [NOISE_W-1:0]             r_noise;
    t_item_ctl                      r_ctl1;

    logic                           ld1;
    logic                           ld2;
    logic                           ld3;
    logic                           ld4;
    logic                           in_fire;
    t_item_ctl                      in_ctl;

    logic [2*COORD_WIDTH-1:0]       sq_x;
    logic [2*COORD_WIDTH-1:0]       sq_y;
    logic signed [DITHER_W-1:0]     dither;
    logic signed [FLICKER_W-1:0]    flicker;
    t_item_ctl                      ctl2;
    logic [RADIUS_W-1:0]            radius;
    logic signed [OFS_W-1:0]        offset;
    t_item_ctl                      ctl3;

    // Stage load enables: a stage loads when it is empty or its item moves on.
    assign ld4        = !r_v4 || i_out_ready;
    assign ld3        = !r_v3 || ld4;
    assign ld2        = !r_v2 || ld3;
    assign ld1        = !r_v1 || ld2;
    assign o_in_ready = ld1;
    assign in_fire    = i_in_valid && ld1;

    assign in_ctl.op    = t_opcode'(i_opcode);
    assign in_ctl.tidx  = i_table_index;
    assign in_ctl.tdata = i_table_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= CENTER_X_RST;
            r_cfg.center_y <= CENTER_Y_RST;
            r_cfg.breathe  <= BREATHE_RST;
            r_cfg.gain     <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data[CENTER_W-1:0];
                CFG_BREATHE:  r_cfg.breathe  <= signed'(i_cfg_data[BREATHE_W-1:0]);
                CFG_GAIN:     r_cfg.gain     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits; only pixel transactions reach the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_in_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3 && ctl3.op == OP_PIXEL;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_pixel_x <= i_pixel_x;
            r_pixel_y <= i_pixel_y;
            r_noise   <= i_noise_sample;
            r_ctl1    <= in_ctl;
        end
    end

    rgpg_geom #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .i_clk          (i_clk),
        .i_load         (ld2),
        .i_pixel_x      (r_pixel_x),
        .i_pixel_y      (r_pixel_y),
        .i_noise_sample (r_noise),
        .i_cfg          (r_cfg),
        .i_ctl          (r_ctl1),
        .o_sq_x         (sq_x),
        .o_sq_y         (sq_y),
        .o_dither       (dither),
        .o_flicker      (flicker),
        .o_ctl          (ctl2)
    );

    rgpg_radius #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_SHIFT (RADIUS_SHIFT)
    ) u_radius (
        .i_clk     (i_clk),
        .i_load    (ld3),
        .i_valid   (r_v2),
        .i_sq_x    (sq_x),
        .i_sq_y    (sq_y),
        .i_dither  (dither),
        .i_flicker (flicker),
        .i_cfg     (r_cfg),
        .i_ctl     (ctl2),
        .o_radius  (radius),
        .o_offset  (offset),
        .o_ctl     (ctl3)
    );

    rgpg_palette u_palette (
        .i_clk         (i_clk),
        .i_load        (ld4),
        .i_valid       (r_v3),
        .i_radius      (radius),
        .i_offset      (offset),
        .i_ctl         (ctl3),
        .o_pixel_color (o_pixel_color)
    );

    assign o_out_valid = r_v4;

    // A new result only comes from a pixel transaction leaving the palette stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3) && $past(ctl3.op) == OP_PIXEL)
        else $error("output became valid without a pixel transaction behind it");

    // With every stage full and the receiver stalled, no transaction is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while the full pipeline is stalled");

    // A transaction accepted into an empty pipeline passes through the input
    // register and is then held in the second stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !r_v1 && !r_v2 |=> ##1 r_v2)
        else $error("accepted transaction did not advance");

    // Reset leaves no result behind.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

[sim/tb_radial_glow_pixel_generator_core.sv]
module tb_radial_glow_pixel_generator_core;

    import rgpg_pkg::*;

    // Opcode that the block must drop without touching any state.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RING_SHIFT      = 9;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [COLOR_W-1:0]     color;
        logic [PIX_COORD_W-1:0] x;
        logic [PIX_COORD_W-1:0] y;
    } pending_color_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OPCODE_W-1:0]     i_opcode;
    logic [PIX_COORD_W-1:0]  i_pixel_x;
    logic [PIX_COORD_W-1:0]  i_pixel_y;
    logic [NOISE_W-1:0]      i_noise_sample;
    logic [IDX_W-1:0]        i_table_index;
    logic [DATA_W-1:0]       i_table_data;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [COLOR_W-1:0]      o_pixel_color;
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    // Predictor state: configuration and both tables, with written flags.
    logic [CENTER_W-1:0]         ctr_x = 10'd240;
    logic [CENTER_W-1:0]         ctr_y = 10'd260;
    logic signed [BREATHE_W-1:0] cfg_breathe = '0;
    logic [GAIN_W-1:0]           cfg_gain = 4'd2;
    logic [RADIUS_W-1:0]         radius_mem [TABLE_DEPTH];
    logic [COLOR_W-1:0]          palette_mem [TABLE_DEPTH];
    bit                          radius_known [TABLE_DEPTH];
    bit                          palette_known [TABLE_DEPTH];
    pending_color_t              pending_colors [$];

    int  errors = 0;
    int  sent_count = 0;
    int  colors_checked = 0;
    int  table_writes = 0;
    int  dropped_count = 0;
    int  cfg_sets = 0;
    bit  tx_idle_on = 1'b1;

    // Receiver pacing state.
    int  hold_req = 0;
    int  hold_ack = 0;
    int  hold_left = 0;
    int  rx_span = 0;
    int  rx_stall = 0;
    bit  rx_steady = 1'b0;
    int  quiet_cycles = 0;

    radial_glow_pixel_generator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_noise_sample (i_noise_sample),
        .i_table_index  (i_table_index),
        .i_table_data   (i_table_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_color  (o_pixel_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Radius table address: squared distance to the center, scaled and saturated.
    function automatic int radius_slot(input logic [PIX_COORD_W-1:0] x,
                                       input logic [PIX_COORD_W-1:0] y);
        int dx;
        int dy;
        int r2;
        dx = int'(x) - int'(ctr_x);
        dy = int'(y) - int'(ctr_y);
        r2 = (dx * dx + dy * dy) >> RING_SHIFT;
        if (r2 > 255) r2 = 255;
        return r2;
    endfunction

    // Palette address: radius value plus dither and flicker, minus breathe, clamped.
    function automatic int palette_slot(input logic [RADIUS_W-1:0] radius,
                                        input logic [PIX_COORD_W-1:0] x,
                                        input logic [PIX_COORD_W-1:0] y,
                                        input logic [NOISE_W-1:0] noise);
        logic [2:0] mix;
        int         b;
        int         dith;
        int         flick;
        int         acc;
        // The 8x8 ordered matrix interleaves the bits of (row ^ col) and row.
        mix   = y[2:0] ^ x[2:0];
        b     = int'({mix[0], y[0], mix[1], y[1], mix[2], y[2]});
        dith  = (b - 31) / 5;
        flick = ((int'(noise) - 128) * int'(cfg_gain)) >>> 7;
        acc   = int'(radius) + dith - int'(cfg_breathe) + flick;
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return acc;
    endfunction

    // Offer one transaction, wait for it to be taken, then update the predictor.
    task automatic push_item(input logic [OPCODE_W-1:0] op,
                             input logic [PIX_COORD_W-1:0] x,
                             input logic [PIX_COORD_W-1:0] y,
                             input logic [NOISE_W-1:0] noise,
                             input logic [IDX_W-1:0] tidx,
                             input logic [DATA_W-1:0] tdata);
        int gap;
        int roll;
        int rs;
        int ps;
        gap = 0;
        if (tx_idle_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 93) gap = $urandom_range(8, 40);
            else if (roll >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_pixel_x      <= x;
        i_pixel_y      <= y;
        i_noise_sample <= noise;
        i_table_index  <= tidx;
        i_table_data   <= tdata;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
        case (op)
            OP_PIXEL: begin
                rs = radius_slot(x, y);
                ps = palette_slot(radius_mem[rs], x, y, noise);
                pending_colors.push_back('{palette_mem[ps], x, y});
            end
            OP_RADIUS_WR: begin
                radius_mem[tidx]   = tdata[RADIUS_W-1:0];
                radius_known[tidx] = 1'b1;
                table_writes++;
            end
            OP_PALETTE_WR: begin
                palette_mem[tidx]   = tdata;
                palette_known[tidx] = 1'b1;
                table_writes++;
            end
            default: dropped_count++;
        endcase
    endtask

    // Send a pixel, first loading any table entry it would read that is still unwritten.
    task automatic push_pixel(input logic [PIX_COORD_W-1:0] x,
                              input logic [PIX_COORD_W-1:0] y,
                              input logic [NOISE_W-1:0] noise);
        int rs;
        int ps;
        rs = radius_slot(x, y);
        if (!radius_known[rs])
            push_item(OP_RADIUS_WR, PIX_COORD_W'($urandom), PIX_COORD_W'($urandom),
                      NOISE_W'($urandom), IDX_W'(rs), DATA_W'($urandom));
        ps = palette_slot(radius_mem[rs], x, y, noise);
        if (!palette_known[ps])
            push_item(OP_PALETTE_WR, PIX_COORD_W'($urandom), PIX_COORD_W'($urandom),
                      NOISE_W'($urandom), IDX_W'(ps), DATA_W'($urandom));
        push_item(OP_PIXEL, x, y, noise, IDX_W'($urandom), DATA_W'($urandom));
    endtask

    // Drain the pipeline, then write all four registers.
    task automatic apply_config(input logic [CFG_DATA_W-1:0] cx,
                                input logic [CFG_DATA_W-1:0] cy,
                                input logic [CFG_DATA_W-1:0] breathe_raw,
                                input logic [CFG_DATA_W-1:0] gain_raw);
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        // Table writes may still be in flight after the last color came out.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_CENTER_X;
        i_cfg_data <= cx;
        @(posedge i_clk);
        i_cfg_addr <= CFG_CENTER_Y;
        i_cfg_data <= cy;
        @(posedge i_clk);
        i_cfg_addr <= CFG_BREATHE;
        i_cfg_data <= breathe_raw;
        @(posedge i_clk);
        i_cfg_addr <= CFG_GAIN;
        i_cfg_data <= gain_raw;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ctr_x       = cx;
        ctr_y       = cy;
        cfg_breathe = breathe_raw[BREATHE_W-1:0];
        cfg_gain    = gain_raw[GAIN_W-1:0];
        cfg_sets++;
    endtask

    // Extreme table addresses and data, and a dropped opcode aimed at a live entry.
    task automatic test_table_writes();
        push_item(OP_RADIUS_WR, '0, '0, '0, 8'd0, 16'hFF00);
        push_item(OP_RADIUS_WR, '0, '0, '0, 8'd255, 16'h00FF);
        push_item(OP_PALETTE_WR, '0, '0, '0, 8'd0, 16'hFFFF);
        push_item(OP_PALETTE_WR, '0, '0, '0, 8'd255, 16'h5A5A);
        push_item(OP_PALETTE_WR, '0, '0, '0, 8'd128, 16'h0000);
        push_item(OP_UNUSED, '1, '1, '1, 8'd0, 16'h00AA);
    endtask

    // Pixels under the register values left by reset.
    task automatic test_reset_defaults();
        push_pixel(10'd240, 10'd260, 8'd128);
        push_pixel(10'd240, 10'd260, 8'd0);
        push_pixel('0, '0, 8'd255);
        push_pixel('1, '1, 8'd0);
    endtask

    // Corner centers, clamping at both ends, zero gain and out-of-range settings.
    task automatic test_config_extremes();
        // Breathe -64 with gain 15 drives the palette index past 255.
        apply_config(10'd0, 10'd0, 10'h040, 10'h00F);
        push_pixel('1, '1, 8'd255);
        push_pixel('0, '0, 8'd0);
        push_pixel(10'd7, 10'd3, 8'd255);
        // Breathe 63 pulls the index below zero; zero gain removes flicker.
        apply_config(10'd1023, 10'd1023, 10'h03F, 10'h000);
        push_pixel('1, '1, 8'd0);
        push_pixel('1, '1, 8'd255);
        push_pixel('0, '0, 8'd0);
        // Upper data bits of the narrow registers must be ignored.
        apply_config(10'd512, 10'd512, 10'h3A3, 10'h3FA);
        push_pixel(10'd512, 10'd512, 8'd0);
        push_pixel(10'd600, 10'd450, 8'd255);
        apply_config(10'd240, 10'd260, 10'h1DD, 10'h3F0);
        push_pixel(10'd250, 10'd255, 8'd200);
    endtask

    // Receiver holds off while the sender keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req++;
        repeat (40)
            push_pixel(PIX_COORD_W'(int'(ctr_x) + int'($urandom_range(0, 80)) - 40),
                       PIX_COORD_W'(int'(ctr_y) + int'($urandom_range(0, 80)) - 40),
                       NOISE_W'($urandom));
        tx_idle_on = 1'b1;
    endtask

    // Mostly pixels near and far from the center, mixed with table rewrites and dropped opcodes.
    task automatic test_random_traffic(input int count);
        int                     roll;
        logic [PIX_COORD_W-1:0] x;
        logic [PIX_COORD_W-1:0] y;
        for (int i = 0; i < count; i++) begin
            if (i % 120 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if ($urandom_range(0, 1) == 0) begin
                    x = PIX_COORD_W'(int'(ctr_x) + int'($urandom_range(0, 720)) - 360);
                    y = PIX_COORD_W'(int'(ctr_y) + int'($urandom_range(0, 720)) - 360);
                end else begin
                    x = PIX_COORD_W'($urandom);
                    y = PIX_COORD_W'($urandom);
                end
                push_pixel(x, y, NOISE_W'($urandom));
            end else if (roll < 82) begin
                push_item(OP_RADIUS_WR, PIX_COORD_W'($urandom), PIX_COORD_W'($urandom),
                          NOISE_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
            end else if (roll < 94) begin
                push_item(OP_PALETTE_WR, PIX_COORD_W'($urandom), PIX_COORD_W'($urandom),
                          NOISE_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
            end else begin
                push_item(OP_UNUSED, PIX_COORD_W'($urandom), PIX_COORD_W'($urandom),
                          NOISE_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
            end
        end
    endtask

    // Output side: steady stretches, random short and long stalls, and requested hold-offs.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_span   <= $urandom_range(30, 250);
                rx_steady <= ($urandom_range(0, 3) == 0);
            end else begin
                rx_span <= rx_span - 1;
            end
            if (rx_steady) begin
                i_out_ready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall    <= rx_stall - 1;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                rx_stall    <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                           : $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transaction with the oldest predicted color.
    always @(posedge i_clk) begin
        pending_color_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected color, expected none, actual %h",
                         $time, o_pixel_color);
                errors++;
            end else begin
                want = pending_colors.pop_front();
                colors_checked++;
                if (o_pixel_color !== want.color) begin
                    $display("%0t: pixel (%0d,%0d) color expected %h actual %h",
                             $time, want.x, want.y, want.color, o_pixel_color);
                    errors++;
                end
            end
        end
    end

    // End the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= '0;
        i_pixel_x      <= '0;
        i_pixel_y      <= '0;
        i_noise_sample <= '0;
        i_table_index  <= '0;
        i_table_data   <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= CFG_CENTER_X;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_writes();
        test_reset_defaults();
        test_config_extremes();

        apply_config(10'd240, 10'd260, 10'h000, 10'h002);
        test_random_traffic(250);
        test_backpressure();
        apply_config(10'd0, 10'd1023, 10'h023, 10'h00A);
        test_random_traffic(250);
        apply_config(10'd1023, 10'd0, 10'h05D, 10'h000);
        test_random_traffic(250);
        repeat (3) begin
            apply_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                         CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            test_random_traffic(250);
        end

        // Let the last colors come out, then watch for strays.
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions: %0d colors checked, %0d table writes, %0d dropped",
                 sent_count, colors_checked, table_writes, dropped_count);
        $display("Register settings applied: %0d, with corner centers and clamp extremes",
                 cfg_sets);
        if (errors == 0 && pending_colors.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/rgpg_pkg.sv
sv/rgpg_geom.sv
sv/rgpg_radius.sv
sv/rgpg_palette.sv
sv/radial_glow_pixel_generator_core.sv
sim/tb_radial_glow_pixel_generator_core.sv
